// File: sv/emsi_hs_pkg.sv
package emsi_hs_pkg;

    // event codes
    localparam logic [3:0] OP_START_C = 4'd0;
    localparam logic [3:0] OP_START_A = 4'd1;
    localparam logic [3:0] OP_INQ     = 4'd2;
    localparam logic [3:0] OP_REQ     = 4'd3;
    localparam logic [3:0] OP_DAT     = 4'd4;
    localparam logic [3:0] OP_ACK     = 4'd5;
    localparam logic [3:0] OP_NAK     = 4'd6;
    localparam logic [3:0] OP_OTHER   = 4'd7;
    localparam logic [3:0] OP_TIMEOUT = 4'd8;

    // action codes
    localparam logic [2:0] ACT_INQ  = 3'd0;
    localparam logic [2:0] ACT_REQ  = 3'd1;
    localparam logic [2:0] ACT_DAT  = 3'd2;
    localparam logic [2:0] ACT_ACK  = 3'd3;
    localparam logic [2:0] ACT_NAK  = 3'd4;
    localparam logic [2:0] ACT_OK   = 3'd5;
    localparam logic [2:0] ACT_FAIL = 3'd6;

    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd6;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_C_WREQ = 3'd1,
        PH_C_WDAT = 3'd2,
        PH_A_WDAT = 3'd3,
        PH_A_WACK = 3'd4
    } t_phase;

    typedef struct packed {
        logic [3:0] op;
        logic       dat_valid;
    } t_in;

    typedef struct packed {
        logic [2:0] action;
        logic       last;
    } t_out;

    // up to three actions for one item, slot 0 goes out first
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][2:0] act;
    } t_burst;

endpackage

// File: sv/emsi_hs_step.sv
module emsi_hs_step (
    input  emsi_hs_pkg::t_in    i_item,
    input  emsi_hs_pkg::t_phase i_phase,
    input  logic [3:0]          i_attempts,
    input  logic [3:0]          i_limit,
    output emsi_hs_pkg::t_phase o_phase,
    output logic [3:0]          o_attempts,
    output emsi_hs_pkg::t_burst o_burst
);

    logic [3:0]          w_lim;
    logic [3:0]          w_att_inc;
    logic                w_hit;
    emsi_hs_pkg::t_burst w_cdat;

    // optional resend followed by an optional verdict
    function automatic emsi_hs_pkg::t_burst pack_two(input logic       pre_en,
                                                     input logic [2:0] pre_act,
                                                     input logic       fin_en,
                                                     input logic [2:0] fin_act);
        emsi_hs_pkg::t_burst b;
        b = '0;
        if (pre_en) begin
            b.act[0] = pre_act;
            b.act[1] = fin_act;
            b.cnt    = fin_en ? 2'd2 : 2'd1;
        end else begin
            b.act[0] = fin_act;
            b.cnt    = fin_en ? 2'd1 : 2'd0;
        end
        return b;
    endfunction

    assign w_lim     = (i_limit == 4'd0) ? 4'd1 : i_limit;
    assign w_att_inc = i_attempts + 4'd1;
    assign w_hit     = (w_att_inc >= w_lim);

    // remote dat seen by the caller
    always_comb begin
        w_cdat = '0;
        if (i_item.dat_valid) begin
            w_cdat.cnt    = 2'd3;
            w_cdat.act[0] = emsi_hs_pkg::ACT_ACK;
            w_cdat.act[1] = emsi_hs_pkg::ACT_ACK;
            w_cdat.act[2] = emsi_hs_pkg::ACT_OK;
        end else begin
            w_cdat.cnt    = 2'd2;
            w_cdat.act[0] = emsi_hs_pkg::ACT_NAK;
            w_cdat.act[1] = emsi_hs_pkg::ACT_FAIL;
        end
    end

    // next state
    always_comb begin
        o_phase    = i_phase;
        o_attempts = i_attempts;
        case (i_item.op)
            emsi_hs_pkg::OP_START_C: begin
                o_phase    = emsi_hs_pkg::PH_C_WREQ;
                o_attempts = 4'd0;
            end
            emsi_hs_pkg::OP_START_A: begin
                o_phase    = emsi_hs_pkg::PH_A_WDAT;
                o_attempts = 4'd0;
            end
            emsi_hs_pkg::OP_INQ, emsi_hs_pkg::OP_REQ, emsi_hs_pkg::OP_DAT,
            emsi_hs_pkg::OP_ACK, emsi_hs_pkg::OP_NAK, emsi_hs_pkg::OP_OTHER,
            emsi_hs_pkg::OP_TIMEOUT: begin
                case (i_phase)
                    emsi_hs_pkg::PH_C_WREQ: begin
                        if (i_item.op == emsi_hs_pkg::OP_REQ) begin
                            o_phase    = emsi_hs_pkg::PH_C_WDAT;
                            o_attempts = 4'd0;
                        end else if (i_item.op == emsi_hs_pkg::OP_DAT || w_hit) begin
                            o_phase    = emsi_hs_pkg::PH_IDLE;
                            o_attempts = 4'd0;
                        end else begin
                            o_attempts = w_att_inc;
                        end
                    end
                    emsi_hs_pkg::PH_C_WDAT: begin
                        if (i_item.op == emsi_hs_pkg::OP_DAT || w_hit) begin
                            o_phase    = emsi_hs_pkg::PH_IDLE;
                            o_attempts = 4'd0;
                        end else begin
                            o_attempts = w_att_inc;
                        end
                    end
                    emsi_hs_pkg::PH_A_WDAT: begin
                        if (i_item.op == emsi_hs_pkg::OP_DAT) begin
                            o_phase    = i_item.dat_valid ? emsi_hs_pkg::PH_A_WACK
                                                          : emsi_hs_pkg::PH_IDLE;
                            o_attempts = 4'd0;
                        end else if (w_hit) begin
                            o_phase    = emsi_hs_pkg::PH_IDLE;
                            o_attempts = 4'd0;
                        end else begin
                            o_attempts = w_att_inc;
                        end
                    end
                    emsi_hs_pkg::PH_A_WACK: begin
                        if (i_item.op == emsi_hs_pkg::OP_ACK || w_hit) begin
                            o_phase    = emsi_hs_pkg::PH_IDLE;
                            o_attempts = 4'd0;
                        end else begin
                            o_attempts = w_att_inc;
                        end
                    end
                    default: begin
                        o_phase = emsi_hs_pkg::PH_IDLE;
                    end
                endcase
            end
            default: begin
                o_phase    = i_phase;
                o_attempts = i_attempts;
            end
        endcase
    end

    // actions
    always_comb begin
        o_burst = '0;
        case (i_item.op)
            emsi_hs_pkg::OP_START_C: begin
                o_burst.cnt    = 2'd1;
                o_burst.act[0] = emsi_hs_pkg::ACT_INQ;
            end
            emsi_hs_pkg::OP_START_A: begin
                o_burst.cnt    = 2'd1;
                o_burst.act[0] = emsi_hs_pkg::ACT_REQ;
            end
            emsi_hs_pkg::OP_INQ, emsi_hs_pkg::OP_REQ, emsi_hs_pkg::OP_DAT,
            emsi_hs_pkg::OP_ACK, emsi_hs_pkg::OP_NAK, emsi_hs_pkg::OP_OTHER,
            emsi_hs_pkg::OP_TIMEOUT: begin
                case (i_phase)
                    emsi_hs_pkg::PH_C_WREQ: begin
                        if (i_item.op == emsi_hs_pkg::OP_REQ) begin
                            o_burst.cnt    = 2'd1;
                            o_burst.act[0] = emsi_hs_pkg::ACT_DAT;
                        end else if (i_item.op == emsi_hs_pkg::OP_DAT) begin
                            o_burst = w_cdat;
                        end else begin
                            o_burst.cnt    = 2'd1;
                            o_burst.act[0] = w_hit ? emsi_hs_pkg::ACT_FAIL
                                                   : emsi_hs_pkg::ACT_INQ;
                        end
                    end
                    emsi_hs_pkg::PH_C_WDAT: begin
                        if (i_item.op == emsi_hs_pkg::OP_DAT) begin
                            o_burst = w_cdat;
                        end else begin
                            o_burst = pack_two(i_item.op == emsi_hs_pkg::OP_NAK,
                                               emsi_hs_pkg::ACT_DAT,
                                               w_hit, emsi_hs_pkg::ACT_FAIL);
                        end
                    end
                    emsi_hs_pkg::PH_A_WDAT: begin
                        if (i_item.op == emsi_hs_pkg::OP_DAT) begin
                            o_burst = pack_two(1'b1,
                                               i_item.dat_valid ? emsi_hs_pkg::ACT_DAT
                                                                : emsi_hs_pkg::ACT_NAK,
                                               !i_item.dat_valid, emsi_hs_pkg::ACT_FAIL);
                        end else begin
                            o_burst = pack_two(i_item.op == emsi_hs_pkg::OP_INQ,
                                               emsi_hs_pkg::ACT_REQ,
                                               w_hit, emsi_hs_pkg::ACT_FAIL);
                        end
                    end
                    emsi_hs_pkg::PH_A_WACK: begin
                        if (i_item.op == emsi_hs_pkg::OP_ACK) begin
                            o_burst.cnt    = 2'd1;
                            o_burst.act[0] = emsi_hs_pkg::ACT_OK;
                        end else begin
                            // answerer out of retries here still succeeds
                            o_burst = pack_two(i_item.op == emsi_hs_pkg::OP_NAK,
                                               emsi_hs_pkg::ACT_DAT,
                                               w_hit, emsi_hs_pkg::ACT_OK);
                        end
                    end
                    default: begin
                        o_burst = '0;
                    end
                endcase
            end
            default: begin
                o_burst = '0;
            end
        endcase
    end

endmodule

// File: sv/emsi_hs_obuf.sv
module emsi_hs_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  emsi_hs_pkg::t_burst i_burst,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output emsi_hs_pkg::t_out   o_out_data
);

    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic [2:0][2:0] r_act;
    logic [2:0][2:0] n_act;
    logic            w_pop;

    assign o_out_valid       = (r_cnt != 2'd0);
    assign o_out_data.action = r_act[0];
    assign o_out_data.last   = (r_cnt == 2'd1);
    assign w_pop             = o_out_valid && i_out_ready;
    assign o_free            = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);

    always_comb begin
        n_cnt = r_cnt;
        n_act = r_act;
        if (i_load) begin
            n_cnt = i_burst.cnt;
            n_act = i_burst.act;
        end else if (w_pop) begin
            n_cnt    = r_cnt - 2'd1;
            n_act[0] = r_act[1];
            n_act[1] = r_act[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_act <= n_act;
    end

endmodule

// File: sv/emsi_handshake_sequencer_core.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in: op, dat_valid)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out: action, last)
// cfg     | input     | i_cfg_we, no wait          | i_cfg_data (retry_limit)
//
// an accepted item is held in the input register until the result buffer is free,
// then its actions are worked out in one pass and loaded into the result buffer
// one item per cycle while each gives at most one action and i_out_ready is high;
// an item with several actions (up to three) holds the result buffer until its last
// one drains, the buffer's drain sets the pace; items with no action leave it empty
// synchronous active-low reset: idle phase, zero attempts, retry limit 6, both
// registers empty
// output stalls back up into the input register and then into o_in_ready
module emsi_handshake_sequencer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  emsi_hs_pkg::t_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output emsi_hs_pkg::t_out   o_out_data,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data
);

    logic                r_in_valid;
    emsi_hs_pkg::t_in    r_in;
    emsi_hs_pkg::t_phase r_phase;
    emsi_hs_pkg::t_phase n_phase;
    logic [3:0]          r_att;
    logic [3:0]          n_att;
    logic [3:0]          r_limit;
    emsi_hs_pkg::t_burst w_burst;
    logic                w_free;
    logic                w_take;

    assign w_take     = r_in_valid && w_free;
    assign o_in_ready = !r_in_valid || w_take;

    emsi_hs_step u_step (
        .i_item     (r_in),
        .i_phase    (r_phase),
        .i_attempts (r_att),
        .i_limit    (r_limit),
        .o_phase    (n_phase),
        .o_attempts (n_att),
        .o_burst    (w_burst)
    );

    emsi_hs_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_take),
        .i_burst     (w_burst),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= emsi_hs_pkg::PH_IDLE;
            r_att      <= 4'd0;
            r_limit    <= emsi_hs_pkg::RETRY_LIMIT_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_take) begin
                r_in_valid <= 1'b0;
            end
            if (w_take) begin
                r_phase <= n_phase;
                r_att   <= n_att;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_attempts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == emsi_hs_pkg::PH_IDLE |-> r_att == 4'd0)
        else $error("attempt count left over in idle phase");

    // the limit may be lowered mid-handshake, but the count never reaches 15
    a_att_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != emsi_hs_pkg::PH_IDLE |-> r_att != 4'd15)
        else $error("attempt count beyond any limit");

    a_start_caller: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && r_in.op == emsi_hs_pkg::OP_START_C
            |=> r_phase == emsi_hs_pkg::PH_C_WREQ && r_att == 4'd0)
        else $error("caller start did not enter wait for req");

    a_burst_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_burst.cnt != 2'd0 |=> o_out_valid)
        else $error("loaded actions not presented");
`endif

endmodule
